[rtl/bol_pkg.sv]
// shared types and constants for the bounded ordered list
// no dependencies
package bol_pkg;

  localparam int CAPACITY = 16;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_END   = 3'd4,
    REQ_DUMP      = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

[rtl/bol_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/bounded_ordered_list.sv]
// bounded ordered list: one ram holds the values as a circular buffer with a head pointer,
// so front and end inserts/removes take no shifting; a position insert shifts the tail
// back one entry at a time (read in S_SHR, write in S_SHW). front/end inserts write the
// ram from idle, removes read via S_RD and S_OUT, dump sends words one by one from S_DUMP.
// one request at a time; the result register frees the input side once taken.
// reset empties the list (count and head cleared); ram contents are not cleared.
module bounded_ordered_list
  import bol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           req_type,
  input  logic signed [31:0]   value,
  input  logic [4:0]           position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   item_value,
  output logic [1:0]           status,
  output logic                 last,
  output logic [4:0]           count_after
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_SHR, S_SHW, S_DUMP, S_OUT} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic [CW-1:0] idx;      // logical index being worked on
  logic [CW-1:0] tgt;      // insert target index
  logic [31:0]   val;
  req_t          req;
  logic          dump_wait;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  bol_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // logical index to physical ram address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, i};
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;

  logic [CW-1:0] pos_c;
  assign pos_c = ({{(CW > 5 ? CW-5 : 0){1'b0}}, position} > count) ? count
                 : CW'(position);

  logic full;
  assign full = (count == CW'(CAPACITY));

  logic [AW-1:0] head_dec;
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  // ram control
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = val;
    raddr = phys(head, idx);
    if (state == S_IDLE && in_valid && out_free && !full) begin
      if (req_type == REQ_INS_FRONT) begin
        we = 1'b1; waddr = head_dec; wdata = value;
      end else if (req_type == REQ_INS_END || (req_type == REQ_INS_POS && pos_c == count)) begin
        we = 1'b1; waddr = phys(head, count); wdata = value;
      end
    end
    if (state == S_SHR) raddr = phys(head, idx - CW'(1));
    if (state == S_SHW) begin
      we = 1'b1;
      waddr = phys(head, idx);
      wdata = (idx == tgt) ? val : rdata;
    end
  end

  logic ovalid_next;
  assign ovalid_next = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head <= '0;
      out_valid <= 1'b0;
      dump_wait <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && out_free) begin
          req <= req_t'(req_type);
          val <= value;
          item_value <= '0;
          last <= 1'b1;
          status <= ST_OK;
          count_after <= 5'(count);
          case (req_type) inside
            REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: begin
              if (full) begin
                status <= ST_FULL; out_valid <= 1'b1;
              end else if (req_type == REQ_INS_FRONT) begin
                head <= head_dec; count <= count + CW'(1);
                count_after <= 5'(count + CW'(1)); out_valid <= 1'b1;
              end else if (req_type == REQ_INS_END || pos_c == count) begin
                count <= count + CW'(1);
                count_after <= 5'(count + CW'(1)); out_valid <= 1'b1;
              end else begin
                // shift entries from count-1 down to pos back by one
                tgt <= pos_c; idx <= count; state <= S_SHR;
              end
            end
            REQ_REM_FRONT, REQ_REM_END, REQ_DUMP: begin
              if (count == '0) begin
                status <= ST_EMPTY; out_valid <= 1'b1;
              end else begin
                idx <= (req_type == REQ_REM_END) ? count - CW'(1) : '0;
                state <= (req_type == REQ_DUMP) ? S_DUMP : S_RD;
                dump_wait <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_RD: state <= S_OUT;   // ram read in flight
        S_OUT: if (out_free) begin
          item_value <= rdata;
          out_valid <= 1'b1;
          count_after <= 5'(count - CW'(1));
          if (req == REQ_REM_FRONT) head <= phys(head, CW'(1));
          count <= count - CW'(1);
          state <= S_IDLE;
        end
        S_SHR: state <= S_SHW;
        S_SHW: begin
          if (idx == tgt) begin
            count <= count + CW'(1);
            count_after <= 5'(count + CW'(1));
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx - CW'(1);
            state <= S_SHR;
          end
        end
        S_DUMP: begin
          // address idx is read each cycle; its data arrives in the next cycle
          if (dump_wait) begin
            dump_wait <= 1'b0;
          end else if (out_free) begin
            item_value <= rdata;
            out_valid <= 1'b1;
            last <= (idx == count - CW'(1));
            if (idx == count - CW'(1)) state <= S_IDLE;
            else begin
              idx <= idx + CW'(1);
              dump_wait <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && !(in_valid && out_free)) out_valid <= ovalid_next;
    end
  end

endmodule
